/* sv/timer_min_heap_scheduler_assert.svh */
// Assertion macros for the timer queue RTL.
`ifndef TIMER_MIN_HEAP_SCHEDULER_ASSERT_SVH
`define TIMER_MIN_HEAP_SCHEDULER_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define TMHS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer queue: same-cycle check failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define TMHS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer queue: next-cycle check failed");

`endif

/* sv/tmhs_pkg.sv */
package tmhs_pkg;

	localparam int CAPACITY  = 64;
	localparam int ID_COUNT  = 1024;
	localparam int TIME_BITS = 32;

	localparam int MODE_W   = 3;
	localparam int ID_W     = 10;
	localparam int TMO_W    = 24;
	localparam int STATUS_W = 2;
	localparam int DLY_W    = 25;
	localparam int MAX_DELAY = 16777215;

	localparam int HA_W  = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CH_W  = HA_W + 2;
	localparam int PA_W  = $clog2(ID_COUNT);

	localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADD    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_ADJUST = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FIRE   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_POP    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 3'd6;
	localparam logic [MODE_W-1:0] MODE_RSVD   = 3'd7;

	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd3;

	typedef enum logic [2:0] {
		RS_ROOT, RS_LAST, RS_POS, RS_LEFT, RS_RIGHT, RS_PARENT
	} rsel_t;

	typedef enum logic [2:0] {
		HL_NONE, HL_ZERO, HL_POS, HL_COUNT, HL_PICK, HL_PARENT
	} hole_t;

	typedef enum logic [1:0] {CL_NONE, CL_NEW, CL_RD} cur_t;
	typedef enum logic [1:0] {WR_NONE, WR_CUR, WR_PICK, WR_RD} wsrc_t;
	typedef enum logic [1:0] {CN_NONE, CN_INC, CN_DEC, CN_CLR} cnt_t;
	typedef enum logic [1:0] {OL_NONE, OL_ONE, OL_FIFO} outld_t;

	typedef struct packed {
		logic                in_ld;
		logic                tick;
		logic                rd;
		rsel_t               rsel;
		logic                pos_rd;
		cur_t                cur_ld;
		hole_t               hole_ld;
		wsrc_t               wr;
		cnt_t                cnt;
		logic                pick_l;
		logic                pick_r;
		logic                fifo_push;
		logic                fifo_rd;
		logic                delay_ld;
		logic                set_status;
		logic [STATUS_W-1:0] status_val;
		logic                set_fired;
		outld_t              out_ld;
	} cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              count_zero;
		logic              full;
		logic              in_range;
		logic              present;
		logic              hole_zero;
		logic              hole_lt_count;
		logic              left_ok;
		logic              right_ok;
		logic              moved;
		logic              cur_before_pick;
		logic              right_before_pick;
		logic              parent_before_cur;
		logic              root_expired;
		logic              nf_zero;
		logic              emit_last;
		logic              out_free;
	} sts_t;

	// Signed wrap-safe ordering of two expiry times.
	function automatic logic earlier(input logic [TIME_BITS-1:0] a,
			input logic [TIME_BITS-1:0] b);
		logic [TIME_BITS-1:0] d;
		d = a - b;
		return d[TIME_BITS-1];
	endfunction

endpackage

/* sv/timer_min_heap_scheduler.sv */
// Channel | Handshake               | Word carried
// input   | in_valid / in_ready     | mode, timer_id, timeout_ms
// output  | out_valid / out_ready   | fired, fired_id, status, next_delay, last
//
// One command is worked at a time; in_ready is high only while the sequencer is idle.
// Each step of a sift is a registered read of the heap memory: the parent when moving up,
// the left and, if in range, the right child when moving down.
// A tick or query removes every expired timer, with a sift for each removal, and then
// emits one fired word per removed timer, or a single word when none expired.
// Reset clears the clock, the timer count and the output valid; no clearing pass runs.
// A stalled output word holds in its register and the sequencer waits behind it.
`include "timer_min_heap_scheduler_assert.svh"

module timer_min_heap_scheduler (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [tmhs_pkg::MODE_W-1:0]         mode,
	input  logic [tmhs_pkg::ID_W-1:0]           timer_id,
	input  logic [tmhs_pkg::TMO_W-1:0]          timeout_ms,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                fired,
	output logic [tmhs_pkg::ID_W-1:0]           fired_id,
	output logic [tmhs_pkg::STATUS_W-1:0]       status,
	output logic signed [tmhs_pkg::DLY_W-1:0]   next_delay,
	output logic                                last
);

	// The controller steps through each command; the datapath holds the heap,
	// the id-to-slot table, the fired-id buffer and the output word register.
	tmhs_pkg::cmd_t cmd;
	tmhs_pkg::sts_t sts;

	tmhs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tmhs_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.mode       (mode),
		.timer_id   (timer_id),
		.timeout_ms (timeout_ms),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.fired      (fired),
		.fired_id   (fired_id),
		.status     (status),
		.next_delay (next_delay),
		.last       (last)
	);

	// Once a command is taken the block is busy for at least the next cycle.
	`TMHS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// Only fired words may be followed by more words of the same command.
	`TMHS_ASSERT_IMP(a_unfired_is_last, out_valid && !fired, last)
	// An error status always stands alone and reports nothing fired.
	`TMHS_ASSERT_IMP(a_error_alone, out_valid && status != tmhs_pkg::ST_OK, last && !fired)
	// The delay is never below minus one.
	`TMHS_ASSERT_IMP(a_delay_range, out_valid, !next_delay[tmhs_pkg::DLY_W-1] || next_delay == '1)

endmodule

/* sv/tmhs_datapath.sv */
module tmhs_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tmhs_pkg::cmd_t                      cmd,
	output tmhs_pkg::sts_t                      sts,
	input  logic [tmhs_pkg::MODE_W-1:0]         mode,
	input  logic [tmhs_pkg::ID_W-1:0]           timer_id,
	input  logic [tmhs_pkg::TMO_W-1:0]          timeout_ms,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic                                fired,
	output logic [tmhs_pkg::ID_W-1:0]           fired_id,
	output logic [tmhs_pkg::STATUS_W-1:0]       status,
	output logic signed [tmhs_pkg::DLY_W-1:0]   next_delay,
	output logic                                last
);

	localparam int TB = tmhs_pkg::TIME_BITS;
	localparam int IW = tmhs_pkg::ID_W;
	localparam int HW = tmhs_pkg::HA_W;
	localparam int CW = tmhs_pkg::CNT_W;
	localparam int XW = tmhs_pkg::CH_W;

	function automatic logic [tmhs_pkg::PA_W-1:0] PA_W_CAST(input logic [IW-1:0] v);
		return tmhs_pkg::PA_W'(v);
	endfunction

	logic [TB+IW-1:0] heap_mem [tmhs_pkg::CAPACITY];
	logic [HW-1:0]    pos_mem  [tmhs_pkg::ID_COUNT];
	logic [IW-1:0]    fifo_mem [tmhs_pkg::CAPACITY];

	logic [tmhs_pkg::MODE_W-1:0]   mode_q;
	logic [IW-1:0]                 id_q;
	logic [tmhs_pkg::TMO_W-1:0]    tmo_q;
	logic [TB-1:0]                 now_q;
	logic [CW-1:0]                 count_q;
	logic [HW-1:0]                 hole_q;
	logic                          moved_q;
	logic [TB-1:0]                 cur_exp_q;
	logic [IW-1:0]                 cur_own_q;
	logic [TB-1:0]                 pick_exp_q;
	logic [IW-1:0]                 pick_own_q;
	logic [HW-1:0]                 pick_idx_q;
	logic [HW-1:0]                 pos_q;
	logic [TB-1:0]                 rd_exp_q;
	logic [IW-1:0]                 rd_own_q;
	logic [IW-1:0]                 fifo_rd_q;
	logic [CW-1:0]                 nf_q;
	logic [CW-1:0]                 rk_q;
	logic signed [tmhs_pkg::DLY_W-1:0] delay_q;
	logic [tmhs_pkg::STATUS_W-1:0] status_q;
	logic                          fired_q;
	logic                          out_valid_q;

	logic [XW-1:0]     left_idx;
	logic [XW-1:0]     right_idx;
	logic [HW-1:0]     parent_idx;
	logic [HW-1:0]     last_idx;
	logic [HW-1:0]     rd_addr;
	logic              wr_en;
	logic [TB-1:0]     wr_exp;
	logic [IW-1:0]     wr_own;
	logic [TB-1:0]     root_diff;
	logic [TB-1:0]     new_exp;
	logic              in_range;

	assign left_idx   = {1'b0, hole_q, 1'b1};
	assign right_idx  = left_idx + XW'(1);
	assign parent_idx = (hole_q - HW'(1)) >> 1;
	assign last_idx   = HW'(count_q - CW'(1));
	assign root_diff  = rd_exp_q - now_q;
	assign new_exp    = now_q + TB'(tmo_q);
	assign in_range   = 32'(id_q) < tmhs_pkg::ID_COUNT;

	always_comb begin
		case (cmd.rsel)
			tmhs_pkg::RS_ROOT:   rd_addr = '0;
			tmhs_pkg::RS_LAST:   rd_addr = last_idx;
			tmhs_pkg::RS_POS:    rd_addr = pos_q;
			tmhs_pkg::RS_LEFT:   rd_addr = left_idx[HW-1:0];
			tmhs_pkg::RS_RIGHT:  rd_addr = right_idx[HW-1:0];
			tmhs_pkg::RS_PARENT: rd_addr = parent_idx;
			default:             rd_addr = '0;
		endcase
	end

	always_comb begin
		wr_en  = 1'b1;
		wr_exp = cur_exp_q;
		wr_own = cur_own_q;
		case (cmd.wr)
			tmhs_pkg::WR_CUR: begin
				wr_exp = cur_exp_q;
				wr_own = cur_own_q;
			end
			tmhs_pkg::WR_PICK: begin
				wr_exp = pick_exp_q;
				wr_own = pick_own_q;
			end
			tmhs_pkg::WR_RD: begin
				wr_exp = rd_exp_q;
				wr_own = rd_own_q;
			end
			default: wr_en = 1'b0;
		endcase
	end

	// Memories and payload registers.
	always_ff @(posedge clk) begin
		if (cmd.in_ld) begin
			mode_q <= mode;
			id_q   <= timer_id;
			tmo_q  <= timeout_ms;
		end
		if (cmd.rd) begin
			rd_exp_q <= heap_mem[rd_addr][TB+IW-1:IW];
			rd_own_q <= heap_mem[rd_addr][IW-1:0];
		end
		if (cmd.pos_rd) begin
			pos_q <= pos_mem[PA_W_CAST(id_q)];
		end
		if (wr_en) begin
			heap_mem[hole_q] <= {wr_exp, wr_own};
			pos_mem[PA_W_CAST(wr_own)] <= hole_q;
		end
		if (cmd.fifo_push) begin
			fifo_mem[nf_q[HW-1:0]] <= rd_own_q;
		end
		if (cmd.fifo_rd) begin
			fifo_rd_q <= fifo_mem[rk_q[HW-1:0]];
		end
		case (cmd.cur_ld)
			tmhs_pkg::CL_NEW: begin
				cur_exp_q <= new_exp;
				cur_own_q <= id_q;
			end
			tmhs_pkg::CL_RD: begin
				cur_exp_q <= rd_exp_q;
				cur_own_q <= rd_own_q;
			end
			default: ;
		endcase
		case (cmd.hole_ld)
			tmhs_pkg::HL_ZERO:   hole_q <= '0;
			tmhs_pkg::HL_POS:    hole_q <= pos_q;
			tmhs_pkg::HL_COUNT:  hole_q <= HW'(count_q);
			tmhs_pkg::HL_PICK:   hole_q <= pick_idx_q;
			tmhs_pkg::HL_PARENT: hole_q <= parent_idx;
			default: ;
		endcase
		if (cmd.hole_ld == tmhs_pkg::HL_PICK) begin
			moved_q <= 1'b1;
		end else if (cmd.hole_ld != tmhs_pkg::HL_NONE) begin
			moved_q <= 1'b0;
		end
		if (cmd.pick_l) begin
			pick_exp_q <= rd_exp_q;
			pick_own_q <= rd_own_q;
			pick_idx_q <= left_idx[HW-1:0];
		end else if (cmd.pick_r) begin
			pick_exp_q <= rd_exp_q;
			pick_own_q <= rd_own_q;
			pick_idx_q <= right_idx[HW-1:0];
		end
		if (cmd.delay_ld) begin
			if (count_q == '0) begin
				delay_q <= '1;
			end else if (root_diff[TB-1]) begin
				delay_q <= '0;
			end else if (64'(root_diff) > 64'(tmhs_pkg::MAX_DELAY)) begin
				delay_q <= tmhs_pkg::DLY_W'(tmhs_pkg::MAX_DELAY);
			end else begin
				delay_q <= tmhs_pkg::DLY_W'(root_diff);
			end
		end
		if (cmd.in_ld) begin
			status_q <= tmhs_pkg::ST_OK;
			fired_q  <= 1'b0;
			nf_q     <= '0;
			rk_q     <= '0;
		end else begin
			if (cmd.set_status) begin
				status_q <= cmd.status_val;
			end
			if (cmd.set_fired) begin
				fired_q <= 1'b1;
			end
			if (cmd.fifo_push) begin
				nf_q <= nf_q + CW'(1);
			end
			if (cmd.out_ld == tmhs_pkg::OL_FIFO) begin
				rk_q <= rk_q + CW'(1);
			end
		end
		case (cmd.out_ld)
			tmhs_pkg::OL_ONE: begin
				fired      <= fired_q;
				fired_id   <= fired_q ? id_q : '0;
				status     <= status_q;
				next_delay <= delay_q;
				last       <= 1'b1;
			end
			tmhs_pkg::OL_FIFO: begin
				fired      <= 1'b1;
				fired_id   <= fifo_rd_q;
				status     <= tmhs_pkg::ST_OK;
				next_delay <= delay_q;
				last       <= (rk_q + CW'(1)) == nf_q;
			end
			default: ;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.tick) begin
				now_q <= now_q + TB'(1);
			end
			case (cmd.cnt)
				tmhs_pkg::CN_INC: count_q <= count_q + CW'(1);
				tmhs_pkg::CN_DEC: count_q <= count_q - CW'(1);
				tmhs_pkg::CN_CLR: count_q <= '0;
				default: ;
			endcase
			if (cmd.out_ld != tmhs_pkg::OL_NONE) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.mode              = mode_q;
		sts.count_zero        = count_q == '0;
		sts.full              = 32'(count_q) >= tmhs_pkg::CAPACITY;
		sts.in_range          = in_range;
		sts.present           = in_range && (CW'(pos_q) < count_q) && (rd_own_q == id_q);
		sts.hole_zero         = hole_q == '0;
		sts.hole_lt_count     = CW'(hole_q) < count_q;
		sts.left_ok           = left_idx < XW'(count_q);
		sts.right_ok          = right_idx < XW'(count_q);
		sts.moved             = moved_q;
		sts.cur_before_pick   = tmhs_pkg::earlier(cur_exp_q, pick_exp_q);
		sts.right_before_pick = tmhs_pkg::earlier(rd_exp_q, pick_exp_q);
		sts.parent_before_cur = tmhs_pkg::earlier(rd_exp_q, cur_exp_q);
		sts.root_expired      = root_diff[TB-1] || (root_diff == '0);
		sts.nf_zero           = nf_q == '0;
		sts.emit_last         = (rk_q + CW'(1)) == nf_q;
		sts.out_free          = !out_valid_q || out_ready;
	end

endmodule

/* sv/tmhs_ctrl.sv */
module tmhs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  tmhs_pkg::sts_t sts,
	output tmhs_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_DISPATCH, S_P_WAIT, S_P_CHK, S_RM_LD, S_RM_CHK,
		S_D_L, S_D_R, S_D_CMP_R, S_D_CMP, S_D_END, S_U_CHK, S_U_CMP,
		S_W_CUR, S_T_RD, S_T_CHK, S_ROOT_RD, S_ROOT_DLY, S_E_ONE,
		S_F_RD, S_F_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;
	state_t after_op;
	logic   scan_mode;

	assign in_ready  = state_q == S_IDLE;
	assign scan_mode = (sts.mode == tmhs_pkg::MODE_TICK) || (sts.mode == tmhs_pkg::MODE_QUERY);
	assign after_op  = scan_mode ? S_T_RD : S_ROOT_RD;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.in_ld = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (sts.mode)
					tmhs_pkg::MODE_TICK: begin
						cmd.tick = 1'b1;
						state_d  = S_T_RD;
					end
					tmhs_pkg::MODE_QUERY: state_d = S_T_RD;
					tmhs_pkg::MODE_ADD, tmhs_pkg::MODE_ADJUST, tmhs_pkg::MODE_FIRE: begin
						cmd.pos_rd = 1'b1;
						state_d    = S_P_WAIT;
					end
					tmhs_pkg::MODE_POP: begin
						if (sts.count_zero) begin
							cmd.set_status = 1'b1;
							cmd.status_val = tmhs_pkg::ST_EMPTY;
							state_d        = S_ROOT_RD;
						end else begin
							cmd.rd      = 1'b1;
							cmd.rsel    = tmhs_pkg::RS_LAST;
							cmd.hole_ld = tmhs_pkg::HL_ZERO;
							state_d     = S_RM_LD;
						end
					end
					tmhs_pkg::MODE_CLEAR: begin
						cmd.cnt = tmhs_pkg::CN_CLR;
						state_d = S_ROOT_RD;
					end
					default: state_d = S_ROOT_RD;
				endcase
			end
			S_P_WAIT: begin
				cmd.rd   = 1'b1;
				cmd.rsel = tmhs_pkg::RS_POS;
				state_d  = S_P_CHK;
			end
			S_P_CHK: begin
				if (sts.present && sts.mode != tmhs_pkg::MODE_FIRE) begin
					cmd.cur_ld  = tmhs_pkg::CL_NEW;
					cmd.hole_ld = tmhs_pkg::HL_POS;
					state_d     = S_D_L;
				end else if (sts.present) begin
					cmd.set_fired = 1'b1;
					cmd.rd        = 1'b1;
					cmd.rsel      = tmhs_pkg::RS_LAST;
					cmd.hole_ld   = tmhs_pkg::HL_POS;
					state_d       = S_RM_LD;
				end else if (sts.mode == tmhs_pkg::MODE_ADD && sts.in_range && sts.full) begin
					cmd.set_status = 1'b1;
					cmd.status_val = tmhs_pkg::ST_FULL;
					state_d        = S_ROOT_RD;
				end else if (sts.mode == tmhs_pkg::MODE_ADD && sts.in_range) begin
					cmd.cur_ld  = tmhs_pkg::CL_NEW;
					cmd.hole_ld = tmhs_pkg::HL_COUNT;
					cmd.cnt     = tmhs_pkg::CN_INC;
					state_d     = S_U_CHK;
				end else begin
					cmd.set_status = 1'b1;
					cmd.status_val = tmhs_pkg::ST_NOTFOUND;
					state_d        = S_ROOT_RD;
				end
			end
			S_RM_LD: begin
				cmd.cur_ld = tmhs_pkg::CL_RD;
				cmd.cnt    = tmhs_pkg::CN_DEC;
				state_d    = S_RM_CHK;
			end
			S_RM_CHK: begin
				state_d = sts.hole_lt_count ? S_D_L : after_op;
			end
			S_D_L: begin
				if (sts.left_ok) begin
					cmd.rd   = 1'b1;
					cmd.rsel = tmhs_pkg::RS_LEFT;
					state_d  = S_D_R;
				end else begin
					state_d = S_D_END;
				end
			end
			S_D_R: begin
				cmd.pick_l = 1'b1;
				if (sts.right_ok) begin
					cmd.rd   = 1'b1;
					cmd.rsel = tmhs_pkg::RS_RIGHT;
					state_d  = S_D_CMP_R;
				end else begin
					state_d = S_D_CMP;
				end
			end
			S_D_CMP_R: begin
				cmd.pick_r = sts.right_before_pick;
				state_d    = S_D_CMP;
			end
			S_D_CMP: begin
				if (sts.cur_before_pick) begin
					state_d = S_D_END;
				end else begin
					cmd.wr      = tmhs_pkg::WR_PICK;
					cmd.hole_ld = tmhs_pkg::HL_PICK;
					state_d     = S_D_L;
				end
			end
			S_D_END: begin
				state_d = sts.moved ? S_W_CUR : S_U_CHK;
			end
			S_U_CHK: begin
				if (sts.hole_zero) begin
					state_d = S_W_CUR;
				end else begin
					cmd.rd   = 1'b1;
					cmd.rsel = tmhs_pkg::RS_PARENT;
					state_d  = S_U_CMP;
				end
			end
			S_U_CMP: begin
				if (sts.parent_before_cur) begin
					state_d = S_W_CUR;
				end else begin
					cmd.wr      = tmhs_pkg::WR_RD;
					cmd.hole_ld = tmhs_pkg::HL_PARENT;
					state_d     = S_U_CHK;
				end
			end
			S_W_CUR: begin
				cmd.wr  = tmhs_pkg::WR_CUR;
				state_d = after_op;
			end
			S_T_RD: begin
				cmd.rd   = 1'b1;
				cmd.rsel = tmhs_pkg::RS_ROOT;
				state_d  = S_T_CHK;
			end
			S_T_CHK: begin
				if (!sts.count_zero && sts.root_expired) begin
					cmd.fifo_push = 1'b1;
					cmd.rd        = 1'b1;
					cmd.rsel      = tmhs_pkg::RS_LAST;
					cmd.hole_ld   = tmhs_pkg::HL_ZERO;
					state_d       = S_RM_LD;
				end else begin
					cmd.delay_ld = 1'b1;
					state_d      = sts.nf_zero ? S_E_ONE : S_F_RD;
				end
			end
			S_ROOT_RD: begin
				cmd.rd   = 1'b1;
				cmd.rsel = tmhs_pkg::RS_ROOT;
				state_d  = S_ROOT_DLY;
			end
			S_ROOT_DLY: begin
				cmd.delay_ld = 1'b1;
				state_d      = S_E_ONE;
			end
			S_E_ONE: begin
				if (sts.out_free) begin
					cmd.out_ld = tmhs_pkg::OL_ONE;
					state_d    = S_IDLE;
				end
			end
			S_F_RD: begin
				cmd.fifo_rd = 1'b1;
				state_d     = S_F_EMIT;
			end
			S_F_EMIT: begin
				if (sts.out_free) begin
					cmd.out_ld = tmhs_pkg::OL_FIFO;
					state_d    = sts.emit_last ? S_IDLE : S_F_RD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
